// File: sv/als_pkg.sv
// Shared types and constants for the anti-aliased line stepper.
// Used by als_divider and antialiased_line_stepper; depends on nothing.

package als_pkg;

	// Default coordinate width of the input endpoints
	localparam int COORD_BITS_DEF = 12;

	// Error accumulator and slope fraction width, weight width
	localparam int ACC_BITS    = 16;
	localparam int WEIGHT_BITS = 8;

	// Divider iteration counter width
	localparam int DIV_CNT_BITS = $clog2(ACC_BITS);

	// Transaction opcodes
	typedef enum logic {
		OP_START   = 1'b0,
		OP_ADVANCE = 1'b1
	} op_t;

	// Line classification
	typedef enum logic [1:0] {
		KIND_HORIZ   = 2'd0,
		KIND_VERT    = 2'd1,
		KIND_DIAG    = 2'd2,
		KIND_GENERAL = 2'd3
	} kind_t;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_DIV  = 2'd1,
		ST_PAIR = 2'd2
	} state_t;

	// Divider status toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// File: sv/antialiased_line_stepper.sv
// Top level of the anti-aliased line stepper: sequencer, stepping datapath, output register.
// Depends on als_pkg and als_divider.

// A start transaction orders the endpoints top to bottom and emits the first pixel,
// exact. For a line that is neither horizontal, vertical nor diagonal the slope
// fraction is then formed by the iterative divider, one quotient bit per cycle, so
// the block holds in_stall until the divider is done. An advance that gives one
// exact pixel returns straight to idle; a weighted step gives the main pixel and
// then its neighbor from the pending register, both going through the single output
// register. Advances after the end of a line are accepted and give nothing. Any
// cycle in which out_stall holds a waiting pixel delays the next transaction.

module antialiased_line_stepper #(
	parameter int COORD_BITS = als_pkg::COORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                operation,
	input  logic signed [COORD_BITS-1:0]        start_x,
	input  logic signed [COORD_BITS-1:0]        start_y,
	input  logic signed [COORD_BITS-1:0]        end_x,
	input  logic signed [COORD_BITS-1:0]        end_y,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [COORD_BITS:0]          pixel_x,
	output logic signed [COORD_BITS:0]          pixel_y,
	output logic [als_pkg::WEIGHT_BITS-1:0]     weight,
	output logic                                exact,
	output logic                                last_pixel
);

	localparam int AB = als_pkg::ACC_BITS;
	localparam int WB = als_pkg::WEIGHT_BITS;
	localparam logic [COORD_BITS:0]   PIX_ONE  = 1;
	localparam logic [COORD_BITS-1:0] STEP_ONE = 1;

	// Sequencer and line state
	als_pkg::state_t         state_q, state_d;
	logic                    active_q, active_d;
	als_pkg::kind_t          kind_q, kind_d;
	logic                    ymaj_q, ymaj_d;
	logic                    xneg_q, xneg_d;
	logic [COORD_BITS:0]     cur_x_q, cur_x_d;
	logic [COORD_BITS:0]     cur_y_q, cur_y_d;
	logic [COORD_BITS:0]     fin_x_q, fin_x_d;
	logic [COORD_BITS:0]     fin_y_q, fin_y_d;
	logic [COORD_BITS-1:0]   steps_q, steps_d;
	logic [AB-1:0]           acc_q, acc_d;
	logic [AB-1:0]           adj_q, adj_d;

	// Pending neighbor pixel
	logic [COORD_BITS:0]     pend_x_q, pend_x_d;
	logic [COORD_BITS:0]     pend_y_q, pend_y_d;
	logic [WB-1:0]           pend_w_q, pend_w_d;

	// Output register
	logic                    out_valid_q, out_valid_d;
	logic [COORD_BITS:0]     px_q, px_d;
	logic [COORD_BITS:0]     py_q, py_d;
	logic [WB-1:0]           w_q, w_d;
	logic                    exact_q, exact_d;
	logic                    last_q, last_d;

	logic                    out_free;
	logic                    in_acc;
	logic                    div_start;
	als_pkg::div_stat_t      div_stat;
	logic [AB-1:0]           div_quot;

	// Start-side decode
	logic                    swap;
	logic [COORD_BITS:0]     s_x0, s_y0, s_x1, s_y1;
	logic [COORD_BITS:0]     dx_s, dy_s;
	logic                    s_neg;
	logic [COORD_BITS-1:0]   s_dx, s_dy;
	logic                    s_ymaj;
	als_pkg::kind_t          s_kind;
	logic [COORD_BITS-1:0]   s_steps;
	logic [COORD_BITS-1:0]   s_minor, s_major;

	// Advance-side values
	logic [COORD_BITS:0]     xstep;
	logic [COORD_BITS:0]     xs, ys;
	logic [AB-1:0]           acc_sum;
	logic                    wrap;
	logic [COORD_BITS:0]     mx, my;
	logic                    adv_last;

	// Endpoint ordering and classification
	always_comb begin
		swap   = start_y > end_y;
		s_x0   = swap ? {end_x[COORD_BITS-1], end_x}     : {start_x[COORD_BITS-1], start_x};
		s_y0   = swap ? {end_y[COORD_BITS-1], end_y}     : {start_y[COORD_BITS-1], start_y};
		s_x1   = swap ? {start_x[COORD_BITS-1], start_x} : {end_x[COORD_BITS-1], end_x};
		s_y1   = swap ? {start_y[COORD_BITS-1], start_y} : {end_y[COORD_BITS-1], end_y};
		dx_s   = s_x1 - s_x0;
		dy_s   = s_y1 - s_y0;
		s_neg  = dx_s[COORD_BITS];
		s_dx   = s_neg ? COORD_BITS'(-dx_s) : dx_s[COORD_BITS-1:0];
		s_dy   = dy_s[COORD_BITS-1:0];
		s_ymaj = s_dy > s_dx;
		s_minor = s_ymaj ? s_dx : s_dy;
		s_major = s_ymaj ? s_dy : s_dx;
		if (s_dy == '0) begin
			s_kind  = als_pkg::KIND_HORIZ;
			s_steps = s_dx;
		end else if (s_dx == '0) begin
			s_kind  = als_pkg::KIND_VERT;
			s_steps = s_dy;
		end else if (s_dx == s_dy) begin
			s_kind  = als_pkg::KIND_DIAG;
			s_steps = s_dy;
		end else begin
			s_kind  = als_pkg::KIND_GENERAL;
			s_steps = s_major;
		end
	end

	// One step along the line
	always_comb begin
		xstep    = xneg_q ? {(COORD_BITS+1){1'b1}} : PIX_ONE;
		xs       = cur_x_q + xstep;
		ys       = cur_y_q + PIX_ONE;
		acc_sum  = acc_q + adj_q;
		wrap     = acc_sum <= acc_q;
		mx       = (ymaj_q && !wrap) ? cur_x_q : xs;
		my       = (!ymaj_q && !wrap) ? cur_y_q : ys;
		adv_last = steps_q == STEP_ONE;
	end

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = !((state_q == als_pkg::ST_IDLE) && out_free);
	assign in_acc   = in_valid && !in_stall;

	// Sequencer: next state and next values
	always_comb begin
		state_d   = state_q;
		active_d  = active_q;
		kind_d    = kind_q;
		ymaj_d    = ymaj_q;
		xneg_d    = xneg_q;
		cur_x_d   = cur_x_q;
		cur_y_d   = cur_y_q;
		fin_x_d   = fin_x_q;
		fin_y_d   = fin_y_q;
		steps_d   = steps_q;
		acc_d     = acc_q;
		adj_d     = adj_q;
		pend_x_d  = pend_x_q;
		pend_y_d  = pend_y_q;
		pend_w_d  = pend_w_q;
		px_d      = px_q;
		py_d      = py_q;
		w_d       = w_q;
		exact_d   = exact_q;
		last_d    = last_q;
		div_start = 1'b0;
		out_valid_d = out_valid_q && out_stall;

		case (state_q)
			als_pkg::ST_IDLE: begin
				if (in_acc && (operation == als_pkg::OP_START)) begin
					kind_d   = s_kind;
					ymaj_d   = s_ymaj;
					xneg_d   = s_neg;
					cur_x_d  = s_x0;
					cur_y_d  = s_y0;
					fin_x_d  = s_x1;
					fin_y_d  = s_y1;
					steps_d  = s_steps;
					acc_d    = '0;
					adj_d    = '0;
					active_d = s_steps != '0;
					px_d     = s_x0;
					py_d     = s_y0;
					w_d      = '0;
					exact_d  = 1'b1;
					last_d   = s_steps == '0;
					out_valid_d = 1'b1;
					if (s_kind == als_pkg::KIND_GENERAL) begin
						div_start = 1'b1;
						state_d   = als_pkg::ST_DIV;
					end
				end else if (in_acc && active_q) begin
					steps_d = steps_q - STEP_ONE;
					out_valid_d = 1'b1;
					if (kind_q != als_pkg::KIND_GENERAL) begin
						// exact step of a straight line
						if (kind_q != als_pkg::KIND_VERT) begin
							cur_x_d = xs;
						end
						if (kind_q != als_pkg::KIND_HORIZ) begin
							cur_y_d = ys;
						end
						active_d = !adv_last;
						px_d     = (kind_q != als_pkg::KIND_VERT) ? xs : cur_x_q;
						py_d     = (kind_q != als_pkg::KIND_HORIZ) ? ys : cur_y_q;
						w_d      = '0;
						exact_d  = 1'b1;
						last_d   = adv_last;
					end else if (adv_last) begin
						// final pixel is the exact endpoint
						active_d = 1'b0;
						cur_x_d  = fin_x_q;
						cur_y_d  = fin_y_q;
						px_d     = fin_x_q;
						py_d     = fin_y_q;
						w_d      = '0;
						exact_d  = 1'b1;
						last_d   = 1'b1;
					end else begin
						// weighted pair: main pixel now, neighbor next
						acc_d    = acc_sum;
						cur_x_d  = mx;
						cur_y_d  = my;
						px_d     = mx;
						py_d     = my;
						w_d      = acc_sum[AB-1:AB-WB];
						exact_d  = 1'b0;
						last_d   = 1'b0;
						pend_x_d = ymaj_q ? (mx + xstep) : mx;
						pend_y_d = ymaj_q ? my : (my + PIX_ONE);
						pend_w_d = ~acc_sum[AB-1:AB-WB];
						state_d  = als_pkg::ST_PAIR;
					end
				end
			end
			als_pkg::ST_DIV: begin
				if (div_stat.done) begin
					adj_d   = div_quot;
					state_d = als_pkg::ST_IDLE;
				end
			end
			als_pkg::ST_PAIR: begin
				if (out_free) begin
					px_d     = pend_x_q;
					py_d     = pend_y_q;
					w_d      = pend_w_q;
					exact_d  = 1'b0;
					last_d   = 1'b0;
					out_valid_d = 1'b1;
					state_d  = als_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = als_pkg::ST_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= als_pkg::ST_IDLE;
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			active_q    <= active_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		kind_q   <= kind_d;
		ymaj_q   <= ymaj_d;
		xneg_q   <= xneg_d;
		cur_x_q  <= cur_x_d;
		cur_y_q  <= cur_y_d;
		fin_x_q  <= fin_x_d;
		fin_y_q  <= fin_y_d;
		steps_q  <= steps_d;
		acc_q    <= acc_d;
		adj_q    <= adj_d;
		pend_x_q <= pend_x_d;
		pend_y_q <= pend_y_d;
		pend_w_q <= pend_w_d;
		px_q     <= px_d;
		py_q     <= py_d;
		w_q      <= w_d;
		exact_q  <= exact_d;
		last_q   <= last_d;
	end

	// Slope fraction divider
	als_divider #(
		.COORD_BITS(COORD_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.numer  (s_minor),
		.denom  (s_major),
		.stat   (div_stat),
		.quot   (div_quot)
	);

	assign out_valid  = out_valid_q;
	assign pixel_x    = px_q;
	assign pixel_y    = py_q;
	assign weight     = w_q;
	assign exact      = exact_q;
	assign last_pixel = last_q;

	// Checks
	a_div_running: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == als_pkg::ST_DIV) |-> (div_stat.busy || div_stat.done))
		else $error("sequencer waits on an idle divider");

	a_pair_holds_main: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == als_pkg::ST_PAIR) |-> out_valid_q)
		else $error("neighbor pending without main pixel in output register");

	a_active_steps: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (steps_q != '0))
		else $error("active line with no steps left");

	a_start_exact: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (operation == als_pkg::OP_START)) |=> (out_valid_q && exact_q))
		else $error("start transaction did not present an exact first pixel");

endmodule

// File: sv/als_divider.sv
// Iterative restoring divider: quotient = (numer << ACC_BITS) / denom, numer < denom.
// One compare-subtract per cycle, one for each quotient bit. Depends on als_pkg.

module als_divider #(
	parameter int COORD_BITS = als_pkg::COORD_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [COORD_BITS-1:0]             numer,
	input  logic [COORD_BITS-1:0]             denom,
	output als_pkg::div_stat_t                stat,
	output logic [als_pkg::ACC_BITS-1:0]      quot
);

	localparam logic [als_pkg::DIV_CNT_BITS-1:0] CNT_LAST =
		als_pkg::DIV_CNT_BITS'(als_pkg::ACC_BITS - 1);
	localparam logic [als_pkg::DIV_CNT_BITS-1:0] CNT_ONE  = 1;

	logic                             busy_q;
	logic                             done_q;
	logic [als_pkg::DIV_CNT_BITS-1:0] cnt_q;
	logic [COORD_BITS-1:0]            rem_q;
	logic [COORD_BITS-1:0]            den_q;
	logic [als_pkg::ACC_BITS-1:0]     quot_q;

	logic [COORD_BITS:0]              shifted;
	logic [COORD_BITS:0]              diff;
	logic                             ge;
	logic [COORD_BITS-1:0]            rem_next;

	// Shared compare-subtract step
	always_comb begin
		shifted  = {rem_q, 1'b0};
		diff     = shifted - {1'b0, den_q};
		ge       = shifted >= {1'b0, den_q};
		rem_next = ge ? diff[COORD_BITS-1:0] : shifted[COORD_BITS-1:0];
	end

	// Control: busy while cnt_q counts down from ACC_BITS-1 to zero, done pulses in the cycle after the last step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_LAST;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_ONE;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= numer;
			den_q  <= denom;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= rem_next;
			quot_q <= {quot_q[als_pkg::ACC_BITS-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quot      = quot_q;

endmodule

// File: tb/als_line_checker.sv
// Scoreboard for the anti-aliased line stepper: watches both channels, predicts pixels.
// Depends on als_pkg for the opcode and line-kind enums and the coordinate, weight and accumulator widths.

module als_line_checker #(
	parameter int COORD_BITS = als_pkg::COORD_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_stall,
	input  logic                              operation,
	input  logic signed [COORD_BITS-1:0]      start_x,
	input  logic signed [COORD_BITS-1:0]      start_y,
	input  logic signed [COORD_BITS-1:0]      end_x,
	input  logic signed [COORD_BITS-1:0]      end_y,
	input  logic                              out_valid,
	input  logic                              out_stall,
	input  logic signed [COORD_BITS:0]        pixel_x,
	input  logic signed [COORD_BITS:0]        pixel_y,
	input  logic [als_pkg::WEIGHT_BITS-1:0]   weight,
	input  logic                              exact,
	input  logic                              last_pixel,
	output int                                fails,
	output int                                pending,
	output int                                n_lines,
	output int                                n_pixels,
	output int                                n_weighted
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WB = als_pkg::WEIGHT_BITS;
	localparam int AB = als_pkg::ACC_BITS;

	typedef struct {
		logic signed [COORD_BITS:0] x;
		logic signed [COORD_BITS:0] y;
		logic [WB-1:0]              w;
		logic                       ex;
		logic                       last;
	} pixel_t;

	pixel_t expected_pixels[$];

	// Shadow copy of the stepper state
	bit                  line_on;
	als_pkg::kind_t      line_kind;
	bit                  y_major;
	bit                  x_neg;
	int                  cur_x, cur_y, fin_x, fin_y;
	int                  steps_left;
	logic [AB-1:0]       err_acc;
	logic [AB-1:0]       err_adj;

	function automatic void queue_pixel(int x, int y, logic [WB-1:0] w, bit ex,
		bit last);
		pixel_t p;
		p.x = (COORD_BITS+1)'(x);
		p.y = (COORD_BITS+1)'(y);
		p.w = w;
		p.ex = ex;
		p.last = last;
		expected_pixels.push_back(p);
	endfunction

	// Pixels caused by one accepted transaction
	function automatic void trace_line_step(als_pkg::op_t op,
		logic signed [COORD_BITS-1:0] sx, logic signed [COORD_BITS-1:0] sy,
		logic signed [COORD_BITS-1:0] ex, logic signed [COORD_BITS-1:0] ey);
		int x0, y0, x1, y1, dx, dy, t, xdir;
		logic [AB-1:0] prev;
		logic [WB-1:0] w;
		bit last;
		if (op == als_pkg::OP_START) begin
			x0 = sx;
			y0 = sy;
			x1 = ex;
			y1 = ey;
			// top to bottom; equal y keeps the given order
			if (y0 > y1) begin
				t = y0; y0 = y1; y1 = t;
				t = x0; x0 = x1; x1 = t;
			end
			dx = x1 - x0;
			dy = y1 - y0;
			x_neg = dx < 0;
			if (dx < 0)
				dx = -dx;
			cur_x = x0;
			cur_y = y0;
			fin_x = x1;
			fin_y = y1;
			err_acc = '0;
			err_adj = '0;
			y_major = dy > dx;
			if (dy == 0) begin
				line_kind = als_pkg::KIND_HORIZ;
				steps_left = dx;
			end else if (dx == 0) begin
				line_kind = als_pkg::KIND_VERT;
				steps_left = dy;
			end else if (dx == dy) begin
				line_kind = als_pkg::KIND_DIAG;
				steps_left = dy;
			end else begin
				line_kind = als_pkg::KIND_GENERAL;
				if (y_major) begin
					err_adj = AB'((longint'(dx) << AB) / longint'(dy));
					steps_left = dy;
				end else begin
					err_adj = AB'((longint'(dy) << AB) / longint'(dx));
					steps_left = dx;
				end
			end
			line_on = steps_left != 0;
			queue_pixel(x0, y0, '0, 1'b1, !line_on);
			n_lines++;
		end else if (line_on) begin
			xdir = x_neg ? -1 : 1;
			steps_left--;
			last = steps_left == 0;
			if (line_kind != als_pkg::KIND_GENERAL) begin
				if (line_kind != als_pkg::KIND_VERT)
					cur_x += xdir;
				if (line_kind != als_pkg::KIND_HORIZ)
					cur_y += 1;
				if (last)
					line_on = 1'b0;
				queue_pixel(cur_x, cur_y, '0, 1'b1, last);
			end else if (last) begin
				// final pixel snaps to the true endpoint
				line_on = 1'b0;
				cur_x = fin_x;
				cur_y = fin_y;
				queue_pixel(fin_x, fin_y, '0, 1'b1, 1'b1);
			end else begin
				prev = err_acc;
				err_acc = err_acc + err_adj;
				// minor axis moves when the accumulator wraps
				if (y_major) begin
					if (err_acc <= prev)
						cur_x += xdir;
					cur_y += 1;
				end else begin
					if (err_acc <= prev)
						cur_y += 1;
					cur_x += xdir;
				end
				w = err_acc[AB-1 -: WB];
				queue_pixel(cur_x, cur_y, w, 1'b0, 1'b0);
				if (y_major)
					queue_pixel(cur_x + xdir, cur_y, ~w, 1'b0, 1'b0);
				else
					queue_pixel(cur_x, cur_y + 1, ~w, 1'b0, 1'b0);
			end
		end
	endfunction

	// Compare one output transaction with the oldest expectation
	function automatic void check_pixel();
		pixel_t e;
		n_pixels++;
		if (!exact)
			n_weighted++;
		if (expected_pixels.size() == 0) begin
			$error("unexpected pixel (%0d,%0d) weight %0d exact %0b last %0b",
				pixel_x, pixel_y, weight, exact, last_pixel);
			fails++;
			return;
		end
		e = expected_pixels.pop_front();
		if (pixel_x !== e.x) begin
			$error("pixel_x: expected %0d, got %0d", e.x, pixel_x);
			fails++;
		end
		if (pixel_y !== e.y) begin
			$error("pixel_y: expected %0d, got %0d", e.y, pixel_y);
			fails++;
		end
		if (weight !== e.w) begin
			$error("weight: expected %0d, got %0d", e.w, weight);
			fails++;
		end
		if (exact !== e.ex) begin
			$error("exact: expected %0b, got %0b", e.ex, exact);
			fails++;
		end
		if (last_pixel !== e.last) begin
			$error("last_pixel: expected %0b, got %0b", e.last, last_pixel);
			fails++;
		end
	endfunction

	// Channel monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_on = 1'b0;
			line_kind = als_pkg::KIND_HORIZ;
			y_major = 1'b0;
			x_neg = 1'b0;
			cur_x = 0;
			cur_y = 0;
			fin_x = 0;
			fin_y = 0;
			steps_left = 0;
			err_acc = '0;
			err_adj = '0;
			expected_pixels.delete();
			fails = 0;
			n_lines = 0;
			n_pixels = 0;
			n_weighted = 0;
		end else begin
			if (in_valid && !in_stall)
				trace_line_step(als_pkg::op_t'(operation), start_x, start_y, end_x, end_y);
			if (out_valid && !out_stall)
				check_pixel();
		end
		pending = expected_pixels.size();
	end

endmodule

// File: tb/tb.sv
// Top of the line stepper testbench: clock, reset, stimulus, receiver stalls, verdict.
// Depends on als_pkg, antialiased_line_stepper and als_line_checker.

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CB        = als_pkg::COORD_BITS_DEF;
	localparam int WB        = als_pkg::WEIGHT_BITS;
	localparam int CMIN      = -(1 << (CB - 1));
	localparam int CMAX      = (1 << (CB - 1)) - 1;
	localparam int LIMIT     = 300000;
	localparam int HOLD_LEN  = 250;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 operation = als_pkg::OP_ADVANCE;
	logic signed [CB-1:0] start_x = '0;
	logic signed [CB-1:0] start_y = '0;
	logic signed [CB-1:0] end_x = '0;
	logic signed [CB-1:0] end_y = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b1;
	logic signed [CB:0]   pixel_x;
	logic signed [CB:0]   pixel_y;
	logic [WB-1:0]        weight;
	logic                 exact;
	logic                 last_pixel;

	int fails, pending, n_lines, n_pixels, n_weighted;
	int send_gap_pct = 0;
	int rcv_stall_pct = 0;
	int hold_reqs = 0;
	int hold_seen = 0;
	int hold_cnt = 0;
	int items_done = 0;
	int cycle_count = 0;

	antialiased_line_stepper #(.COORD_BITS(CB)) u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .operation(operation),
		.start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
		.out_valid(out_valid), .out_stall(out_stall),
		.pixel_x(pixel_x), .pixel_y(pixel_y), .weight(weight),
		.exact(exact), .last_pixel(last_pixel)
	);

	als_line_checker #(.COORD_BITS(CB)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .operation(operation),
		.start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
		.out_valid(out_valid), .out_stall(out_stall),
		.pixel_x(pixel_x), .pixel_y(pixel_y), .weight(weight),
		.exact(exact), .last_pixel(last_pixel),
		.fails(fails), .pending(pending), .n_lines(n_lines),
		.n_pixels(n_pixels), .n_weighted(n_weighted)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Receiver: random stalls, or one long hold-off counted here
	always @(posedge clk) begin
		if (hold_cnt > 0) begin
			hold_cnt = hold_cnt - 1;
			out_stall <= 1'b1;
		end else if (hold_seen != hold_reqs) begin
			hold_seen = hold_reqs;
			hold_cnt = HOLD_LEN;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rcv_stall_pct);
		end
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == LIMIT) begin
			$display("timeout after %0d cycles, %0d pixels still expected", cycle_count, pending);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// One input transaction; returns in the step of the accepting edge
	task automatic send_item(als_pkg::op_t op, logic signed [CB-1:0] ax,
		logic signed [CB-1:0] ay, logic signed [CB-1:0] bx, logic signed [CB-1:0] by);
		bit ok;
		if ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		start_x <= ax;
		start_y <= ay;
		end_x <= bx;
		end_y <= by;
		do begin
			@(negedge clk);
			ok = !in_stall;
			@(posedge clk);
		end while (!ok);
	endtask

	// Start a line, then a given number of advances with junk endpoint fields
	task automatic run_line(int x0, int y0, int x1, int y1, int adv);
		int ax, ay, steps;
		ax = x1 > x0 ? x1 - x0 : x0 - x1;
		ay = y1 > y0 ? y1 - y0 : y0 - y1;
		steps = ax > ay ? ax : ay;
		send_item(als_pkg::OP_START, CB'(x0), CB'(y0), CB'(x1), CB'(y1));
		for (int i = 0; i < adv; i++)
			send_item(als_pkg::OP_ADVANCE, CB'($urandom), CB'($urandom), CB'($urandom),
				CB'($urandom));
		items_done += 1 + (adv < steps ? adv : steps);
	endtask

	function automatic int clamp_coord(int v);
		return v > CMAX ? CMAX : (v < CMIN ? CMIN : v);
	endfunction

	// Mostly short complete lines; some cut short by a new start, some given extra advances past the end
	task automatic random_line();
		int x0, y0, x1, y1, dx, dy, mag, pick, steps, adv;
		x0 = $urandom_range(CMAX - CMIN) + CMIN;
		y0 = $urandom_range(CMAX - CMIN) + CMIN;
		pick = $urandom_range(99);
		mag = pick < 70 ? 10 : (pick < 90 ? 40 : CMAX - CMIN);
		dx = $urandom_range(mag);
		dy = $urandom_range(mag);
		case ($urandom_range(9))
			0: dy = 0;
			1: dx = 0;
			2: dy = dx;
			3: begin
				dx = 0;
				dy = 0;
			end
			default: ;
		endcase
		if ($urandom_range(1))
			dx = -dx;
		if ($urandom_range(1))
			dy = -dy;
		if (x0 + dx > CMAX || x0 + dx < CMIN)
			dx = -dx;
		if (y0 + dy > CMAX || y0 + dy < CMIN)
			dy = -dy;
		x1 = clamp_coord(x0 + dx);
		y1 = clamp_coord(y0 + dy);
		dx = x1 > x0 ? x1 - x0 : x0 - x1;
		dy = y1 > y0 ? y1 - y0 : y0 - y1;
		steps = dx > dy ? dx : dy;
		if (steps > 40)
			adv = $urandom_range(1, 30);
		else if ($urandom_range(9) == 0)
			adv = $urandom_range(steps);
		else if ($urandom_range(3) == 0)
			adv = steps + $urandom_range(1, 2);
		else
			adv = steps;
		run_line(x0, y0, x1, y1, adv);
	endtask

	// Sender pause until every expected pixel is out
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: idle advance, single point, each line kind, swap, restart
		send_gap_pct = 0;
		rcv_stall_pct <= 30;
		send_item(als_pkg::OP_ADVANCE, CB'(CMIN), CB'(CMAX), CB'(CMIN), CB'(CMAX));
		run_line(CMIN, CMAX, CMIN, CMAX, 2);
		run_line(CMAX, CMIN, CMAX - 2, CMIN, 2);
		run_line(CMIN, CMAX, CMIN, CMAX - 2, 2);
		run_line(CMAX - 2, CMIN, CMAX, CMIN + 2, 2);
		run_line(CMIN + 2, CMAX, CMIN, CMAX - 5, 5);
		run_line(CMIN, CMIN, CMAX, CMIN + 1, 3);
		run_line(CMAX, CMAX, CMIN, CMIN, 3);
		wait_drained();

		// Sender rarely idle, receiver mostly stalled
		send_gap_pct = 11;
		rcv_stall_pct <= 80;
		while (items_done < 300)
			random_line();
		wait_drained();

		// Sender mostly idle, receiver rarely stalled
		send_gap_pct = 80;
		rcv_stall_pct <= 11;
		while (items_done < 580)
			random_line();
		wait_drained();

		// Full rate, opening with a long receiver hold-off to back up the block
		send_gap_pct = 0;
		rcv_stall_pct <= 0;
		hold_reqs <= hold_reqs + 1;
		while (items_done < 850)
			random_line();
		wait_drained();

		repeat (40) @(posedge clk);
		$display("covered %0d lines over %0d transactions: %0d pixels checked, %0d weighted",
			n_lines, items_done, n_pixels, n_weighted);
		$display("all line kinds, endpoint swaps, restarts mid-line and idle advances driven");
		if (fails == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: antialiased_line_stepper.f
sv/als_pkg.sv
sv/als_divider.sv
sv/antialiased_line_stepper.sv
tb/als_line_checker.sv
tb/tb.sv
